// ===== rtl/clws_pkg.sv =====
// clws_pkg: shared types, constants and helpers of the character-LCD write sequencer.
// No dependencies; every other file of the block but clws_ifs refers to it by scoped names.
package clws_pkg;

   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned DATA_W      = 8;
   localparam int unsigned HOLD_W      = 16;
   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 16;

   // reset values of the configuration registers
   localparam logic              RST_FOUR_BIT_MODE   = 1'b1;
   localparam logic              RST_UPPER_PINS      = 1'b0;
   localparam logic [DATA_W-1:0] RST_CURSOR_CMD_BASE = 8'h80;
   localparam logic [HOLD_W-1:0] RST_STEP_HOLD_TICKS = 16'd1000;

   localparam logic [DATA_W-1:0] HIGH_NIBBLE_MASK = 8'hF0;
   localparam logic [DATA_W-1:0] LOW_NIBBLE_MASK  = 8'h0F;

   typedef enum logic [1:0] {
      OP_COMMAND   = 2'd0,
      OP_CHARACTER = 2'd1,
      OP_CURSOR    = 2'd2
   } op_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FOUR_BIT_MODE   = 2'd0,
      CSR_UPPER_PINS      = 2'd1,
      CSR_CURSOR_CMD_BASE = 2'd2,
      CSR_STEP_HOLD_TICKS = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic              four_bit_mode;
      logic              upper_pins;
      logic [DATA_W-1:0] cursor_cmd_base;
      logic [HOLD_W-1:0] step_hold_ticks;
   } cfg_type;

   // classified request as queued between front and back
   typedef struct packed {
      logic              reg_select;
      logic [DATA_W-1:0] bus_byte;
   } cmd_type;

   function automatic logic [DATA_W-1:0] row_offset(input logic [1:0] row);
      logic [DATA_W-1:0] offs;
      case (row)
         2'd0:    offs = 8'h00;
         2'd1:    offs = 8'h40;
         2'd2:    offs = 8'h10;
         default: offs = 8'h50;
      endcase
      return offs;
   endfunction

endpackage

// ===== rtl/clws_ifs.sv =====
// clws_ifs: valid/ready channel interfaces of the sequencer (request, response, csr).
// Depends on nothing; widths match the fields held in clws_pkg.
interface clws_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] op;
   logic [7:0] value;
   logic [1:0] row;
   logic [5:0] col;
   modport source (output valid, op, value, row, col, input ready);
   modport sink   (input valid, op, value, row, col, output ready);
endinterface

interface clws_rsp_if;
   logic       valid;
   logic       ready;
   logic       reg_select;
   logic       read_write;
   logic       enable;
   logic [7:0] data_lines;
   logic       last;
   modport source (output valid, reg_select, read_write, enable, data_lines, last,
                   input ready);
   modport sink   (input valid, reg_select, read_write, enable, data_lines, last,
                   output ready);
endinterface

interface clws_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [15:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/clws_front.sv =====
// clws_front: accepts requests, turns each into register select and bus byte.
// Depends on clws_pkg and clws_req_if.
module clws_front (
   clws_req_if.sink                       req_bus,
   input  logic [clws_pkg::DATA_W-1:0]    cursor_cmd_base,
   input  logic                           queue_full,
   output logic                           push,
   output clws_pkg::cmd_type              push_cmd
);

   logic                        accept;
   logic                        known_op;
   logic [clws_pkg::DATA_W-1:0] cursor_addr;

   assign req_bus.ready = !queue_full;
   assign accept        = req_bus.valid && req_bus.ready;

   // column is added as given; the sum fits the byte
   assign cursor_addr = {2'b00, req_bus.col} + clws_pkg::row_offset(req_bus.row);

   always_comb begin
      known_op            = 1'b1;
      push_cmd.reg_select = 1'b0;
      push_cmd.bus_byte   = req_bus.value;
      case (req_bus.op)
         clws_pkg::OP_COMMAND: begin
            push_cmd.reg_select = 1'b0;
         end
         clws_pkg::OP_CHARACTER: begin
            push_cmd.reg_select = 1'b1;
         end
         clws_pkg::OP_CURSOR: begin
            push_cmd.bus_byte = cursor_addr | cursor_cmd_base;
         end
         default: begin
            known_op = 1'b0;   // unused op: taken and dropped
         end
      endcase
   end

   assign push = accept && known_op;

endmodule

// ===== rtl/clws_fifo.sv =====
// clws_fifo: short request queue decoupling the front from the pin sequencer.
// Depends on clws_pkg for the queued entry type.
module clws_fifo #(
   parameter int unsigned DEPTH = clws_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  clws_pkg::cmd_type push_cmd,
   output logic              full,
   input  logic              pop,
   output clws_pkg::cmd_type pop_cmd,
   output logic              not_empty
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   clws_pkg::cmd_type mem_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff,  count_in;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_cmd   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("queue written while full");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("queue read while empty");

endmodule

// ===== rtl/clws_back.sv =====
// clws_back: steps each queued byte out as LCD pin states, holding each step.
// Depends on clws_pkg and clws_rsp_if.
module clws_back (
   input  logic              clock,
   input  logic              reset,
   input  clws_pkg::cfg_type cfg,
   input  logic              queue_valid,
   input  clws_pkg::cmd_type queue_cmd,
   output logic              pop,
   clws_rsp_if.source        rsp_bus
);

   localparam logic [2:0] STEP_HIGH   = 3'd2;  // byte, or high nibble
   localparam logic [2:0] STEP_LOW    = 3'd5;  // low nibble
   localparam logic [2:0] STEP_LAST_8 = 3'd3;
   localparam logic [2:0] STEP_LAST_4 = 3'd6;

   logic                          active_ff;
   logic [2:0]                    step_ff;
   clws_pkg::cmd_type             cmd_ff;
   logic [clws_pkg::HOLD_W-1:0]   timer_ff;
   logic [clws_pkg::DATA_W-1:0]   held_ff;
   logic                          rsp_valid_ff;
   logic                          rsp_rs_ff;
   logic                          rsp_en_ff;
   logic [clws_pkg::DATA_W-1:0]   rsp_data_ff;
   logic                          rsp_last_ff;

   logic                          issue;
   logic                          out_free;
   logic                          is_last;
   logic [2:0]                    last_step;
   logic                          en_level;
   logic [clws_pkg::DATA_W-1:0]   data_in;
   logic [clws_pkg::HOLD_W-1:0]   timer_load;

   function automatic logic [clws_pkg::DATA_W-1:0] place_nibble(
      input logic [clws_pkg::DATA_W-1:0] held,
      input logic [3:0]                  nib,
      input logic                        upper);
      logic [clws_pkg::DATA_W-1:0] placed;
      if (upper) begin
         placed = (held & clws_pkg::LOW_NIBBLE_MASK) | {nib, 4'b0000};
      end else begin
         placed = (held & clws_pkg::HIGH_NIBBLE_MASK) | {4'b0000, nib};
      end
      return placed;
   endfunction

   assign last_step = cfg.four_bit_mode ? STEP_LAST_4 : STEP_LAST_8;
   assign is_last   = (step_ff == last_step);
   assign out_free  = !rsp_valid_ff || rsp_bus.ready;
   assign issue     = active_ff && (timer_ff == '0) && out_free;
   assign pop       = queue_valid && (!active_ff || (issue && is_last));

   // hold of zero behaves as a hold of one
   assign timer_load = (cfg.step_hold_ticks == '0) ? '0 : cfg.step_hold_ticks - 1'b1;

   always_comb begin
      case (step_ff) inside
         3'd0, 3'd3, 3'd6: en_level = 1'b0;
         default:          en_level = 1'b1;
      endcase
   end

   always_comb begin
      data_in = held_ff;
      if (step_ff == STEP_HIGH) begin
         data_in = cfg.four_bit_mode
                   ? place_nibble(held_ff, cmd_ff.bus_byte[7:4], cfg.upper_pins)
                   : cmd_ff.bus_byte;
      end else if ((step_ff == STEP_LOW) && cfg.four_bit_mode) begin
         data_in = place_nibble(held_ff, cmd_ff.bus_byte[3:0], cfg.upper_pins);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         step_ff      <= '0;
         timer_ff     <= '0;
         held_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (timer_ff != '0) begin
            timer_ff <= timer_ff - 1'b1;
         end
         if (issue) begin
            rsp_valid_ff <= 1'b1;
            held_ff      <= data_in;
            timer_ff     <= timer_load;
            step_ff      <= step_ff + 1'b1;
            if (is_last) begin
               active_ff <= 1'b0;
            end
         end
         if (pop) begin
            active_ff <= 1'b1;
            step_ff   <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         cmd_ff <= queue_cmd;
      end
      if (issue) begin
         rsp_rs_ff   <= cmd_ff.reg_select;
         rsp_en_ff   <= en_level;
         rsp_data_ff <= data_in;
         rsp_last_ff <= is_last;
      end
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.reg_select = rsp_rs_ff;
   assign rsp_bus.read_write = 1'b0;
   assign rsp_bus.enable     = rsp_en_ff;
   assign rsp_bus.data_lines = rsp_data_ff;
   assign rsp_bus.last       = rsp_last_ff;

   a_issue_shows: assert property (@(posedge clock) disable iff (reset)
      issue |=> rsp_valid_ff)
      else $error("issued step not presented");

   a_step_in_range: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> (step_ff <= last_step))
      else $error("step counter past final step");

   a_held_only_on_issue: assert property (@(posedge clock) disable iff (reset)
      !issue |=> $stable(held_ff))
      else $error("held data changed without a step");

endmodule

// ===== rtl/char_lcd_write_sequencer_unit.sv =====
// char_lcd_write_sequencer_unit: top level of the character-LCD write sequencer.
// Depends on clws_pkg, clws_ifs, clws_front, clws_fifo and clws_back.
//
// Takes write requests (command byte, character byte, or cursor row/column) and plays
// out the parallel-bus pin states of each, one response per step: 4 steps on the
// 8-bit bus, 7 in 4-bit mode (high nibble then low nibble on lines 7..4 or 3..0, the
// other four lines keeping their held level). A cursor request sends
// cursor_cmd_base OR (column + row offset 0x00/0x40/0x10/0x50). Op code 3 is taken
// and dropped. Each step is held by the step timer in the back end, loaded from
// step_hold_ticks (a hold of zero acting as a hold of one), and waits while the
// last step has not been taken. A queue of QUEUE_DEPTH requests lets new requests
// be taken while a write is still being played out, and an output register holds
// each step until it is taken; the next step issues once it is free or being taken.
// Configuration registers are written through the csr channel, which never stalls,
// and should only be changed while no request is in flight.
module char_lcd_write_sequencer_unit #(
   parameter int unsigned QUEUE_DEPTH = clws_pkg::QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   clws_req_if.sink   req_bus,
   clws_rsp_if.source rsp_bus,
   clws_csr_if.sink   csr_bus
);

   clws_pkg::cfg_type cfg_ff;
   clws_pkg::cmd_type push_cmd;
   clws_pkg::cmd_type queue_cmd;
   logic              push;
   logic              pop;
   logic              queue_full;
   logic              queue_valid;
   logic              csr_write;

   // --- configuration registers ---
   assign csr_bus.ready = 1'b1;
   assign csr_write     = csr_bus.valid && csr_bus.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.four_bit_mode   <= clws_pkg::RST_FOUR_BIT_MODE;
         cfg_ff.upper_pins      <= clws_pkg::RST_UPPER_PINS;
         cfg_ff.cursor_cmd_base <= clws_pkg::RST_CURSOR_CMD_BASE;
         cfg_ff.step_hold_ticks <= clws_pkg::RST_STEP_HOLD_TICKS;
      end else if (csr_write) begin
         case (clws_pkg::csr_index_type'(csr_bus.index))
            clws_pkg::CSR_FOUR_BIT_MODE:   cfg_ff.four_bit_mode   <= csr_bus.data[0];
            clws_pkg::CSR_UPPER_PINS:      cfg_ff.upper_pins      <= csr_bus.data[0];
            clws_pkg::CSR_CURSOR_CMD_BASE: cfg_ff.cursor_cmd_base <= csr_bus.data[7:0];
            clws_pkg::CSR_STEP_HOLD_TICKS: cfg_ff.step_hold_ticks <= csr_bus.data;
            default: begin
               // no other registers
            end
         endcase
      end
   end

   // --- front: accept and classify requests ---
   clws_front u_front (
      .req_bus         (req_bus),
      .cursor_cmd_base (cfg_ff.cursor_cmd_base),
      .queue_full      (queue_full),
      .push            (push),
      .push_cmd        (push_cmd)
   );

   // --- request queue ---
   clws_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .full      (queue_full),
      .pop       (pop),
      .pop_cmd   (queue_cmd),
      .not_empty (queue_valid)
   );

   // --- back: pin step sequencer with hold timer ---
   clws_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .queue_valid (queue_valid),
      .queue_cmd   (queue_cmd),
      .pop         (pop),
      .rsp_bus     (rsp_bus)
   );

endmodule

// ===== dv/tb_char_lcd_write_sequencer_unit.sv =====
// tb_char_lcd_write_sequencer_unit: self-checking testbench of the character-LCD write sequencer.
// Depends on clws_pkg, clws_ifs and char_lcd_write_sequencer_unit; predicts every pin step
// of each request and checks the response stream step by step under random back-pressure.
`timescale 1ns / 1ps

module tb_char_lcd_write_sequencer_unit;

   // op code the block takes and drops
   localparam logic [1:0] OP_UNUSED = 2'd3;
   // no handshake on any channel for this long means the block has hung; the longest
   // legal quiet stretch is one step at the maximum hold plus the drain pause after it
   localparam int unsigned QUIET_LIMIT = 200000;
   // extra cycles of settling past the hold time before a register write or the end
   localparam int unsigned SETTLE_SLACK = 20;

   typedef struct {
      logic       reg_select;
      logic       read_write;
      logic       enable;
      logic [7:0] data_lines;
      logic       last;
   } pin_step_type;

   logic clock;
   logic reset;

   clws_req_if req_bus ();
   clws_rsp_if rsp_bus ();
   clws_csr_if csr_bus ();

   char_lcd_write_sequencer_unit dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // ---------------------------------------------------------------------
   // Predictor state: shadow of the registers and of the data-line level
   // ---------------------------------------------------------------------
   logic        lcd_four_bit;
   logic        lcd_upper_pins;
   logic [7:0]  lcd_cursor_base;
   logic [15:0] lcd_hold_ticks;
   logic [7:0]  bus_level;

   pin_step_type expected_pin_steps[$];
   int unsigned  error_count;

   // traffic shaping knobs, changed by the tests
   int unsigned send_idle_pct;
   int unsigned stall_pct;
   int unsigned hold_off_left;
   int unsigned quiet_cycles;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------------
   function automatic logic [7:0] place_nibble(logic [7:0] level, logic [3:0] nib);
      // only the selected half of the bus moves; the other half keeps its level
      if (lcd_upper_pins)
         return {nib, level[3:0]};
      return {level[7:4], nib};
   endfunction

   task automatic push_pin_step(logic rs, logic en, logic [7:0] level, logic fin);
      pin_step_type s;
      s.reg_select = rs;
      s.read_write = 1'b0;
      s.enable     = en;
      s.data_lines = level;
      s.last       = fin;
      expected_pin_steps.push_back(s);
   endtask

   // works out every pin step of one bus write and queues them
   task automatic plan_bus_write(logic [1:0] op, logic [7:0] value, logic [1:0] row,
                                 logic [5:0] col);
      logic       rs;
      logic [7:0] bus_byte;
      logic [7:0] offs;
      logic [7:0] level;
      if (op == OP_UNUSED)
         return;
      case (row)
         2'd0:    offs = 8'h00;
         2'd1:    offs = 8'h40;
         2'd2:    offs = 8'h10;
         default: offs = 8'h50;
      endcase
      if (op == clws_pkg::OP_CURSOR) begin
         // column added as given, even past the visible display
         rs       = 1'b0;
         bus_byte = (8'(col) + offs) | lcd_cursor_base;
      end else begin
         rs       = (op == clws_pkg::OP_CHARACTER);
         bus_byte = value;
      end
      level = bus_level;
      push_pin_step(rs, 1'b0, level, 1'b0);
      push_pin_step(rs, 1'b1, level, 1'b0);
      if (lcd_four_bit) begin
         level = place_nibble(level, bus_byte[7:4]);
         push_pin_step(rs, 1'b1, level, 1'b0);
         push_pin_step(rs, 1'b0, level, 1'b0);
         push_pin_step(rs, 1'b1, level, 1'b0);
         level = place_nibble(level, bus_byte[3:0]);
         push_pin_step(rs, 1'b1, level, 1'b0);
         push_pin_step(rs, 1'b0, level, 1'b1);
      end else begin
         level = bus_byte;
         push_pin_step(rs, 1'b1, level, 1'b0);
         push_pin_step(rs, 1'b0, level, 1'b1);
      end
      bus_level = level;
   endtask

   // ---------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------
   // Offers one request and returns at the edge it is taken. valid is left high so
   // that a request straight after keeps it high; anything that pauses lowers it.
   task automatic send_request(logic [1:0] op, logic [7:0] value, logic [1:0] row,
                               logic [5:0] col);
      if ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.op    <= op;
      req_bus.value <= value;
      req_bus.row   <= row;
      req_bus.col   <= col;
      do @(posedge clock); while (!req_bus.ready);
      plan_bus_write(op, value, row, col);
   endtask

   task automatic send_random_request();
      int unsigned pick;
      logic [1:0]  op;
      logic [5:0]  col;
      pick = $urandom_range(99);
      if (pick < 30)      op = clws_pkg::OP_COMMAND;
      else if (pick < 65) op = clws_pkg::OP_CHARACTER;
      else if (pick < 93) op = clws_pkg::OP_CURSOR;
      else                op = OP_UNUSED;
      // mostly on-screen columns, some beyond the display
      if ($urandom_range(99) < 70) col = 6'($urandom_range(39));
      else                         col = 6'($urandom_range(63, 40));
      send_request(op, 8'($urandom), 2'($urandom), col);
   endtask

   // stops offering, waits for every predicted step, then lets the final hold run out
   task automatic wait_until_drained();
      int unsigned settle;
      req_bus.valid <= 1'b0;
      while (expected_pin_steps.size() != 0) @(posedge clock);
      settle = (lcd_hold_ticks == 16'd0 ? 1 : lcd_hold_ticks) + SETTLE_SLACK;
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_register(clws_pkg::csr_index_type idx, logic [15:0] data);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= data;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      case (idx)
         clws_pkg::CSR_FOUR_BIT_MODE:   lcd_four_bit    = data[0];
         clws_pkg::CSR_UPPER_PINS:      lcd_upper_pins  = data[0];
         clws_pkg::CSR_CURSOR_CMD_BASE: lcd_cursor_base = data[7:0];
         default:                       lcd_hold_ticks  = data;
      endcase
      @(posedge clock);
   endtask

   // drains the block before writing the registers
   task automatic apply_settings(logic four_bit, logic upper, logic [7:0] base,
                                 logic [15:0] hold);
      wait_until_drained();
      write_register(clws_pkg::CSR_FOUR_BIT_MODE, 16'(four_bit));
      write_register(clws_pkg::CSR_UPPER_PINS, 16'(upper));
      write_register(clws_pkg::CSR_CURSOR_CMD_BASE, 16'(base));
      write_register(clws_pkg::CSR_STEP_HOLD_TICKS, hold);
   endtask

   // ---------------------------------------------------------------------
   // Response side: random stalls, plus a long hold-off counted down here
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (hold_off_left != 0) begin
         rsp_bus.ready <= 1'b0;
         hold_off_left = hold_off_left - 1;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // each taken pin step against the oldest prediction
   always @(posedge clock) begin
      pin_step_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_pin_steps.size() == 0) begin
            $error("pin step with no request outstanding: data_lines %0h", rsp_bus.data_lines);
            error_count++;
         end else begin
            want = expected_pin_steps.pop_front();
            if (rsp_bus.reg_select !== want.reg_select) begin
               $error("reg_select: expected %0h, got %0h", want.reg_select, rsp_bus.reg_select);
               error_count++;
            end
            if (rsp_bus.read_write !== want.read_write) begin
               $error("read_write: expected %0h, got %0h", want.read_write, rsp_bus.read_write);
               error_count++;
            end
            if (rsp_bus.enable !== want.enable) begin
               $error("enable: expected %0h, got %0h", want.enable, rsp_bus.enable);
               error_count++;
            end
            if (rsp_bus.data_lines !== want.data_lines) begin
               $error("data_lines: expected %0h, got %0h", want.data_lines, rsp_bus.data_lines);
               error_count++;
            end
            if (rsp_bus.last !== want.last) begin
               $error("last: expected %0h, got %0h", want.last, rsp_bus.last);
               error_count++;
            end
         end
      end
   end

   // hang detection: any handshake on any channel counts as progress
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || (csr_bus.valid && csr_bus.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles = quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb_char_lcd_write_sequencer_unit: errors");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------
   // settings straight out of reset: 4-bit on lines 3..0, cursor base 0x80, hold 1000
   task automatic test_reset_settings();
      send_request(clws_pkg::OP_CURSOR, 8'h00, 2'd3, 6'd39);
      send_request(clws_pkg::OP_CHARACTER, 8'hA5, 2'd0, 6'd0);
   endtask

   // full 8-bit bus, every op, byte extremes, first and far rows, dropped op
   task automatic test_eight_bit_bus();
      apply_settings(1'b0, 1'b0, 8'h80, 16'd1);
      send_request(clws_pkg::OP_COMMAND, 8'h00, 2'd3, 6'd63);
      send_request(clws_pkg::OP_COMMAND, 8'hFF, 2'd0, 6'd0);
      send_request(clws_pkg::OP_CHARACTER, 8'h5A, 2'd1, 6'd1);
      send_request(clws_pkg::OP_CURSOR, 8'hFF, 2'd0, 6'd0);
      send_request(clws_pkg::OP_CURSOR, 8'h00, 2'd1, 6'd63);
      send_request(OP_UNUSED, 8'hFF, 2'd3, 6'd63);
      send_request(clws_pkg::OP_CHARACTER, 8'h81, 2'd2, 6'd20);
   endtask

   // nibble transfers on each half of the bus, cursor base at both extremes
   task automatic test_four_bit_bus();
      apply_settings(1'b1, 1'b1, 8'hFF, 16'd2);
      send_request(clws_pkg::OP_CHARACTER, 8'hA5, 2'd0, 6'd0);
      send_request(clws_pkg::OP_CURSOR, 8'h00, 2'd2, 6'd39);
      send_request(clws_pkg::OP_COMMAND, 8'h3C, 2'd0, 6'd0);
      apply_settings(1'b1, 1'b0, 8'h00, 16'd1);
      send_request(clws_pkg::OP_CURSOR, 8'h00, 2'd3, 6'd63);
      send_request(OP_UNUSED, 8'h00, 2'd0, 6'd0);
      send_request(clws_pkg::OP_COMMAND, 8'hF0, 2'd1, 6'd5);
      send_request(clws_pkg::OP_CHARACTER, 8'h0F, 2'd0, 6'd0);
   endtask

   // a hold of zero is taken as written and still gives the same pin values
   task automatic test_zero_hold();
      apply_settings(1'b0, 1'b1, 8'h55, 16'd0);
      send_request(clws_pkg::OP_CHARACTER, 8'hFF, 2'd0, 6'd0);
      send_request(clws_pkg::OP_COMMAND, 8'h00, 2'd0, 6'd0);
      send_request(clws_pkg::OP_CURSOR, 8'h00, 2'd1, 6'd42);
   endtask

   // one short request at the longest hold
   task automatic test_longest_hold();
      apply_settings(1'b0, 1'b0, 8'h80, 16'hFFFF);
      send_request(clws_pkg::OP_CHARACTER, 8'hC3, 2'd0, 6'd0);
   endtask

   // receiver holds off while requests keep coming, so the queue fills and the
   // input stalls; then the sender stops until every step is back and sends four more
   task automatic test_backpressure();
      apply_settings(1'b1, 1'b0, 8'h80, 16'd1);
      send_idle_pct = 0;
      stall_pct     = 0;
      hold_off_left = 400;
      repeat (10) send_random_request();
      wait_until_drained();
      repeat (4) send_random_request();
   endtask

   task automatic run_random_phase(int unsigned count, int unsigned idle, int unsigned stall,
                                   logic four_bit, logic upper, logic [7:0] base,
                                   logic [15:0] hold);
      apply_settings(four_bit, upper, base, hold);
      send_idle_pct = idle;
      stall_pct     = stall;
      repeat (count) send_random_request();
   endtask

   task automatic test_random_traffic();
      run_random_phase(24, 0, 0, 1'b0, 1'b0, 8'($urandom), 16'd1);
      run_random_phase(28, 55, 0, 1'b1, 1'b0, 8'($urandom), 16'd2);
      run_random_phase(28, 0, 55, 1'b1, 1'b1, 8'h80, 16'd1);
      run_random_phase(28, 23, 23, 1'b0, 1'b1, 8'hFF, 16'd3);
      // mixed settings to finish, with no idling
      run_random_phase(8, 0, 0, 1'b1, 1'($urandom), 8'($urandom), 16'd1);
   endtask

   initial begin
      // shadow registers start at their reset values
      lcd_four_bit    = 1'b1;
      lcd_upper_pins  = 1'b0;
      lcd_cursor_base = 8'h80;
      lcd_hold_ticks  = 16'd1000;
      bus_level       = 8'h00;
      error_count     = 0;
      send_idle_pct   = 0;
      stall_pct       = 0;
      hold_off_left   = 0;
      quiet_cycles    = 0;

      reset         <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.op    <= clws_pkg::OP_COMMAND;
      req_bus.value <= 8'h00;
      req_bus.row   <= 2'd0;
      req_bus.col   <= 6'd0;
      csr_bus.valid <= 1'b0;
      csr_bus.index <= clws_pkg::CSR_FOUR_BIT_MODE;
      csr_bus.data  <= 16'h0000;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_settings();
      test_eight_bit_bus();
      test_four_bit_bus();
      test_zero_hold();
      test_longest_hold();
      test_backpressure();
      test_random_traffic();
      wait_until_drained();

      if (error_count == 0 && expected_pin_steps.size() == 0) begin
         $display("tb_char_lcd_write_sequencer_unit: clean");
      end else begin
         $display("tb_char_lcd_write_sequencer_unit: errors");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/clws_pkg.sv
rtl/clws_ifs.sv
rtl/clws_front.sv
rtl/clws_fifo.sv
rtl/clws_back.sv
rtl/char_lcd_write_sequencer_unit.sv
dv/tb_char_lcd_write_sequencer_unit.sv
